FILE: hdl/label_majority_tracker_unit_defines.svh
// assertion macros for the label majority tracker checker
// no dependencies; expects i_clk and i_rst_n in the scope of use
`ifndef LABEL_MAJORITY_TRACKER_UNIT_DEFINES_SVH
`define LABEL_MAJORITY_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define LMT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define LMT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lmt_pkg.sv
// shared types, constants and helpers for the label majority tracker
// no dependencies
package lmt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int COUNT_BITS  = 32;
    localparam int LABEL_BITS  = 16;
    localparam int OUT_COUNT_BITS = 32;
    localparam int OUT_USED_BITS  = 5;
    localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_BITS = $clog2(TABLE_DEPTH + 1);

    typedef logic [LABEL_BITS-1:0] t_label;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [USED_BITS-1:0]  t_used;

    localparam t_label WINNER_RESET = '1;
    localparam t_count COUNT_ONE    = t_count'(1);
    localparam t_count COUNT_MAX    = '1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture label, start a new scan
        logic scan;    // issue the next table read
        logic finish;  // write back and present the result
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic issue_done;  // a read has been issued for every entry in use
        logic rd_pending;  // a read is still in flight
    } t_status;

    // saturating increment of an occurrence count
    function automatic t_count sat_inc(input t_count c);
        return (c == COUNT_MAX) ? c : t_count'(c + COUNT_ONE);
    endfunction

endpackage

FILE: hdl/label_majority_tracker_unit.sv
// label majority tracker: start captures the label, a table scan then reads one entry
// per cycle and tracks the largest count, and finish writes the table back and
// registers the result; start is taken again in the o_done cycle, not before
// results cannot be stalled; o_done is high for one cycle per transaction
// synchronous active-low reset empties the table and sets the majority label to -1
module label_majority_tracker_unit import lmt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_label,
    output logic               o_done,
    output logic signed [15:0] o_majority_label,
    output logic        [31:0] o_majority_count,
    output logic        [4:0]  o_distinct_used,
    output logic               o_dropped
);

    t_cmd    cmd;
    t_status status;
    t_label  winner;
    t_count  best;
    t_used   used;

    // sequencing
    lmt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // tables and scan logic
    lmt_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_label   (t_label'(i_label)),
        .o_status  (status),
        .o_done    (o_done),
        .o_winner  (winner),
        .o_best    (best),
        .o_used    (used),
        .o_dropped (o_dropped)
    );

    // result ports
    assign o_majority_label = signed'(winner);
    assign o_majority_count = OUT_COUNT_BITS'(best);
    assign o_distinct_used  = OUT_USED_BITS'(used);

endmodule

FILE: hdl/lmt_ram.sv
// generic single write port ram with registered read
// no dependencies
module lmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lmt_ctrl.sv
// controller state machine for the label majority tracker
// depends on lmt_pkg
module lmt_ctrl import lmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.issue_done && !i_status.rd_pending) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: hdl/lmt_datapath.sv
// datapath: label and count tables, lookup and max scan, result registers
// depends on lmt_pkg and lmt_ram
module lmt_datapath import lmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_label  i_label,
    output t_status o_status,
    output logic    o_done,
    output t_label  o_winner,
    output t_count  o_best,
    output t_used   o_used,
    output logic    o_dropped
);

    t_label r_lab;
    logic   r_found;
    t_addr  r_hit;
    t_count r_hit_cnt;
    t_count r_best;
    t_label r_winner;
    t_used  r_used;
    t_used  r_rd_addr;
    logic   r_rd_valid;
    t_addr  r_rd_idx;
    logic   r_done;
    logic   r_dropped;

    logic   rd_issue;
    t_label rd_label;
    t_count rd_count;
    logic   rd_match;
    t_count rd_eff;
    logic   full;
    logic   we_label;
    logic   we_count;
    t_addr  waddr;
    t_count wcount;

    // table storage
    lmt_ram #(.WIDTH(LABEL_BITS), .DEPTH(TABLE_DEPTH)) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (we_label),
        .i_waddr (waddr),
        .i_wdata (r_lab),
        .i_re    (rd_issue),
        .i_raddr (r_rd_addr[ADDR_BITS-1:0]),
        .o_rdata (rd_label)
    );

    lmt_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (we_count),
        .i_waddr (waddr),
        .i_wdata (wcount),
        .i_re    (rd_issue),
        .i_raddr (r_rd_addr[ADDR_BITS-1:0]),
        .o_rdata (rd_count)
    );

    // read issue and compare of the returning entry
    assign rd_issue = i_cmd.scan && (r_rd_addr != r_used);
    assign rd_match = (rd_label == r_lab) && !r_found;
    assign rd_eff   = rd_match ? sat_inc(rd_count) : rd_count;

    // write back on finish: bump a hit, append a new label, or drop it when full
    assign full     = (r_used == t_used'(TABLE_DEPTH));
    assign we_label = i_cmd.finish && !r_found && !full;
    assign we_count = i_cmd.finish && (r_found || !full);
    assign waddr    = r_found ? r_hit : r_used[ADDR_BITS-1:0];
    assign wcount   = r_found ? r_hit_cnt : COUNT_ONE;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_winner   <= WINNER_RESET;
            r_rd_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_rd_valid <= rd_issue;
            r_done     <= i_cmd.finish;
            if (r_rd_valid && (rd_eff > r_best)) begin
                r_winner <= rd_label;
            end
            if (i_cmd.finish && !r_found && !full) begin
                r_used <= t_used'(r_used + 1'b1);
                if (r_best == '0) begin
                    r_winner <= r_lab;
                end
            end
        end
    end

    // per-transaction working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lab     <= i_label;
            r_found   <= 1'b0;
            r_best    <= '0;
            r_rd_addr <= '0;
        end else begin
            if (rd_issue) begin
                r_rd_addr <= t_used'(r_rd_addr + 1'b1);
                r_rd_idx  <= r_rd_addr[ADDR_BITS-1:0];
            end
            if (r_rd_valid) begin
                if (rd_match) begin
                    r_found   <= 1'b1;
                    r_hit     <= r_rd_idx;
                    r_hit_cnt <= rd_eff;
                end
                if (rd_eff > r_best) begin
                    r_best <= rd_eff;
                end
            end
            if (i_cmd.finish) begin
                r_dropped <= !r_found && full;
                if (!r_found && !full && (r_best == '0)) begin
                    r_best <= COUNT_ONE;
                end
            end
        end
    end

    assign o_status.issue_done = (r_rd_addr == r_used);
    assign o_status.rd_pending = r_rd_valid;
    assign o_done    = r_done;
    assign o_winner  = r_winner;
    assign o_best    = r_best;
    assign o_used    = r_used;
    assign o_dropped = r_dropped;

endmodule

FILE: hdl/lmt_checker.sv
// port-level checker for the label majority tracker, bound to the top level
// depends on lmt_pkg and label_majority_tracker_unit_defines.svh
`include "label_majority_tracker_unit_defines.svh"

module lmt_checker import lmt_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic signed [15:0] i_label,
    input logic               o_done,
    input logic signed [15:0] o_majority_label,
    input logic        [31:0] o_majority_count,
    input logic        [4:0]  o_distinct_used,
    input logic               o_dropped
);

    // a result is only shown once the unit has gone idle
    `LMT_ASSERT_NOW(a_done_idle, o_done, !busy, "result while still busy")

    // an accepted transaction makes the unit busy
    `LMT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "start accepted but not busy")

    // every result has at least one entry and a nonzero majority count
    `LMT_ASSERT_NOW(a_result_sane, o_done,
        (o_distinct_used != '0) && (o_distinct_used <= OUT_USED_BITS'(TABLE_DEPTH)) &&
        (o_majority_count != '0), "result with empty table or zero count")

    // a drop is only reported with a full table
    `LMT_ASSERT_NOW(a_drop_full, o_done && o_dropped,
        o_distinct_used == OUT_USED_BITS'(TABLE_DEPTH), "drop with room left in table")

endmodule

bind label_majority_tracker_unit lmt_checker u_lmt_checker (.*);

FILE: sim/tb_top.sv
// testbench for label_majority_tracker_unit: directed label rows, then weighted random labels
// each result is checked against a typed row's values or a running tally of labels
// kept alongside the block; depends on lmt_pkg (hdl/lmt_pkg.sv) and the block itself
module tb_top;
    import lmt_pkg::*;

    // one expected or observed result
    typedef struct packed {
        t_label      lab;
        logic [31:0] cnt;
        logic [4:0]  used;
        logic        drop;
    } t_majority;

    // one row of the directed part
    typedef struct {
        t_label    lab;
        bit        typed;
        t_majority want;
    } t_probe;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_label;
    logic               o_done;
    logic signed [15:0] o_majority_label;
    logic        [31:0] o_majority_count;
    logic        [4:0]  o_distinct_used;
    logic               o_dropped;

    // running tally of labels, mirrors the block's table
    t_label    tally_label_store [TABLE_DEPTH];
    t_count    tally_count_store [TABLE_DEPTH];
    int        tally_used;
    t_label    leader_label;

    t_majority pending_majority [$];
    t_probe    probe_rows [$];
    t_majority oldest;
    int        fail_count;

    label_majority_tracker_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_label          (i_label),
        .o_done           (o_done),
        .o_majority_label (o_majority_label),
        .o_majority_count (o_majority_count),
        .o_distinct_used  (o_distinct_used),
        .o_dropped        (o_dropped)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = ~i_clk;
    end

    // insert one label into the tally and work out the majority that follows
    function automatic t_majority tally_insert(input t_label lab);
        int        hit;
        t_count    best;
        t_majority r;
        hit = -1;
        r.drop = 1'b0;
        for (int i = 0; i < tally_used; i++) begin
            if (hit < 0 && tally_label_store[i] == lab) hit = i;
        end
        if (hit >= 0) begin
            if (tally_count_store[hit] != COUNT_MAX)
                tally_count_store[hit] = tally_count_store[hit] + 1'b1;
        end else if (tally_used < TABLE_DEPTH) begin
            tally_label_store[tally_used] = lab;
            tally_count_store[tally_used] = 1;
            tally_used++;
        end else begin
            r.drop = 1'b1;
        end
        // strictly greater, so the earliest entry keeps a tie
        best = '0;
        for (int i = 0; i < tally_used; i++) begin
            if (tally_count_store[i] > best) begin
                best = tally_count_store[i];
                leader_label = tally_label_store[i];
            end
        end
        r.lab  = leader_label;
        r.cnt  = best[31:0];
        r.used = 5'(tally_used);
        return r;
    endfunction

    // offer one label after a gap, then record what it should produce
    task automatic send_label(input t_label lab, input int unsigned gap, input bit typed,
                              input t_majority want);
        t_majority r;
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start   = 1'b1;
        i_label = lab;
        do @(posedge i_clk); while (busy);
        r = tally_insert(lab);
        if (typed) r = want;
        pending_majority = {pending_majority, r};
    endtask

    // hold off until every outstanding transaction has reported
    task automatic drain_results;
        @(negedge i_clk);
        start = 1'b0;
        while (pending_majority.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input t_label lab, input bit typed, input t_label wl,
                           input int wc, input int wu, input bit wd);
        t_probe p;
        p.lab  = lab;
        p.typed = typed;
        p.want = '{wl, 32'(wc), 5'(wu), wd};
        probe_rows = {probe_rows, p};
    endtask

    task automatic report(input string field, input longint unsigned want,
                          input longint unsigned got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        fail_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_majority.size() == 0) begin
                $display("%0t: result with nothing expected, label %0h count %0h",
                         $time, o_majority_label, o_majority_count);
                fail_count++;
            end else begin
                oldest = pending_majority.pop_front();
                if (o_majority_label !== oldest.lab)
                    report("majority_label", oldest.lab, o_majority_label);
                if (o_majority_count !== oldest.cnt)
                    report("majority_count", oldest.cnt, o_majority_count);
                if (o_distinct_used !== oldest.used)
                    report("distinct_used", oldest.used, o_distinct_used);
                if (o_dropped !== oldest.drop)
                    report("dropped", oldest.drop, o_dropped);
            end
        end
    end

    // stimulus
    initial begin
        t_label lab;
        int     fav;
        int     pick;
        bit     steady;
        fail_count   = 0;
        tally_used   = 0;
        leader_label = '1;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_label      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, ties resolved to the earliest entry, -1 as a real label
        add_row(16'h8000, 1, 16'h8000, 1, 1, 0);
        add_row(16'h7FFF, 1, 16'h8000, 1, 2, 0);
        add_row(16'h7FFF, 1, 16'h7FFF, 2, 2, 0);
        add_row(16'h0000, 1, 16'h7FFF, 2, 3, 0);
        add_row(16'hFFFF, 1, 16'h7FFF, 2, 4, 0);
        add_row(16'h8000, 1, 16'h8000, 2, 4, 0);
        add_row(16'hFFFF, 1, 16'h8000, 2, 4, 0);
        add_row(16'hFFFF, 1, 16'hFFFF, 3, 4, 0);
        // fill the rest of the table with assorted bit patterns
        add_row(16'h5555, 0, '0, 0, 0, 0);
        add_row(16'hAAAA, 0, '0, 0, 0, 0);
        add_row(16'h0001, 0, '0, 0, 0, 0);
        add_row(16'hFFFE, 0, '0, 0, 0, 0);
        add_row(16'h0100, 0, '0, 0, 0, 0);
        add_row(16'h8001, 0, '0, 0, 0, 0);
        add_row(16'h7FFE, 0, '0, 0, 0, 0);
        add_row(16'h00FF, 0, '0, 0, 0, 0);
        add_row(16'h1111, 0, '0, 0, 0, 0);
        add_row(16'h2222, 0, '0, 0, 0, 0);
        add_row(16'h3333, 0, '0, 0, 0, 0);
        add_row(16'h4444, 0, '0, 0, 16'd16, 0);
        // full table: new label dropped, majority unchanged
        add_row(16'h1234, 1, 16'hFFFF, 3, 16, 1);
        add_row(16'h4444, 0, '0, 0, 0, 0);
        foreach (probe_rows[k])
            send_label(probe_rows[k].lab, $urandom_range(0, 17), probe_rows[k].typed,
                       probe_rows[k].want);
        drain_results();

        // random phases, each leaning on one entry so the leader moves around
        for (int phase = 0; phase < 15; phase++) begin
            fav    = $urandom_range(0, TABLE_DEPTH - 1);
            steady = (phase % 3 == 0);
            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(0, 99);
                if (tally_used == 0 || pick < 15)
                    lab = t_label'($urandom);
                else if (pick < 70 && fav < tally_used)
                    lab = tally_label_store[fav];
                else
                    lab = tally_label_store[$urandom_range(0, tally_used - 1)];
                send_label(lab, steady ? 0 : $urandom_range(0, 17), 1'b0, '0);
            end
            if (phase % 4 == 1) drain_results();
        end

        // wind down and let the last transaction settle
        drain_results();
        repeat (25) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("timeout waiting for the block");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
